// File: hw/rtl/ordered_dither_1bpp_packer_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the ordered dither packer
// Shared assertion forms, clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ORDERED_DITHER_1BPP_PACKER_TOP_DEFINES_SVH
`define ORDERED_DITHER_1BPP_PACKER_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define ODP_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication
`define ODP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define ODP_ASSERT_NOW(label, ante, cons, msg)
`define ODP_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// File: hw/rtl/odp_pkg.sv
// ----------------------------------------------------------------------------
// odp_pkg
// Types and constants of the ordered dither 1bpp packer.
// ----------------------------------------------------------------------------
package odp_pkg;

   localparam int DITHER_MAX_SIDE  = 16;
   // largest tile log2 whose side still fits DITHER_MAX_SIDE
   localparam int MAX_SIDE_LOG2    = $clog2(DITHER_MAX_SIDE + 1) - 1;
   localparam int LOG2_W           = 3;

   localparam int PIXELS_PER_GROUP = 8;
   localparam int PIXEL_W          = 8;
   localparam int TABLE_DEPTH      = 256;
   localparam int TABLE_AW         = $clog2(TABLE_DEPTH);
   localparam int NUM_BANKS        = PIXELS_PER_GROUP;
   localparam int BANK_SEL_W       = $clog2(NUM_BANKS);
   localparam int BANK_DEPTH       = TABLE_DEPTH / NUM_BANKS;
   localparam int BANK_AW          = $clog2(BANK_DEPTH);

   localparam logic [PIXEL_W-1:0] FIXED_THRESHOLD = 8'd128;

   typedef enum logic {
      CMD_TABLE_WRITE = 1'b0,
      CMD_CONVERT     = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      CSR_INVERT_OUTPUT      = 2'd0,
      CSR_DITHER_ENABLE      = 2'd1,
      CSR_DITHER_WIDTH_LOG2  = 2'd2,
      CSR_DITHER_HEIGHT_LOG2 = 2'd3
   } csr_index_type;

   typedef struct packed {
      cmd_type     cmd;
      logic [31:0] pixels_left;
      logic [31:0] pixels_right;
      logic [5:0]  byte_column;
      logic [7:0]  pixel_row;
      logic [7:0]  table_slot;
      logic [7:0]  table_level;
   } odp_req_type;

   typedef struct packed {
      logic [7:0] packed_byte;
      logic [5:0] out_column;
      logic [7:0] out_row;
   } odp_rsp_type;

   // table write port
   typedef struct packed {
      logic                en;
      logic [TABLE_AW-1:0] slot;
      logic [PIXEL_W-1:0]  level;
   } tbl_wr_type;

   // table read port: one row address shared by all banks
   typedef struct packed {
      logic               en;
      logic [BANK_AW-1:0] addr;
   } tbl_rd_type;

endpackage

// File: hw/rtl/odp_table.sv
// ----------------------------------------------------------------------------
// odp_table
// Dither table split into one bank per pixel of a group, registered reads.
// ----------------------------------------------------------------------------
module odp_table
   import odp_pkg::*;
(
   input  logic                                    clock,
   input  tbl_wr_type                              wr,
   input  tbl_rd_type                              rd,
   output logic [NUM_BANKS-1:0][PIXEL_W-1:0]       rd_data
);

   for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
      logic [PIXEL_W-1:0] mem_ff [BANK_DEPTH];
      logic [PIXEL_W-1:0] rd_data_ff;

      always_ff @(posedge clock) begin
         if (wr.en && (wr.slot[BANK_SEL_W-1:0] == BANK_SEL_W'(b))) begin
            mem_ff[wr.slot[TABLE_AW-1:BANK_SEL_W]] <= wr.level;
         end
         if (rd.en) begin
            rd_data_ff <= mem_ff[rd.addr];
         end
      end

      assign rd_data[b] = rd_data_ff;
   end

endmodule

// File: hw/rtl/ordered_dither_1bpp_packer_top.sv
// ----------------------------------------------------------------------------
// ordered_dither_1bpp_packer_top
// Packs eight gray pixels into one 1-bit display byte, ordered dither or
// fixed threshold, with a loadable 256-entry dither table.
// ----------------------------------------------------------------------------
// The block takes one item per clock while req_stall is low; a convert result
// passes the table read register (loaded with stage 1) and then the result
// register; a table-write item produces no result. The rate is set by
// the dither table, which is split into eight 32-entry banks by the low three
// index bits: the eight entries one group needs always share one bank row, so
// every bank is read once per item. A table write lands in the table at the
// edge it is accepted, so a convert in the very next cycle already sees it.
// Reads of table entries never written since reset return undefined data.
// req_stall rises only while the result register is full and rsp_stall holds
// it. Configuration (csr_*) is always ready and must only change while idle.
`include "ordered_dither_1bpp_packer_top_defines.svh"

module ordered_dither_1bpp_packer_top
   import odp_pkg::*;
(
   input  logic          clock,
   input  logic          reset,

   input  logic          req_valid,
   output logic          req_stall,
   input  odp_req_type   req_item,

   output logic          rsp_valid,
   input  logic          rsp_stall,
   output odp_rsp_type   rsp_item,

   input  logic          csr_valid,
   output logic          csr_ready,
   input  csr_index_type csr_index,
   input  logic [2:0]    csr_wdata
);

   // ---------------------------------------------------------------- config
   logic              invert_ff, invert_in;
   logic              dither_en_ff, dither_en_in;
   logic [LOG2_W-1:0] width_log2_ff, width_log2_in;
   logic [LOG2_W-1:0] height_log2_ff, height_log2_in;

   assign csr_ready = 1'b1;

   always_comb begin
      invert_in      = invert_ff;
      dither_en_in   = dither_en_ff;
      width_log2_in  = width_log2_ff;
      height_log2_in = height_log2_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_INVERT_OUTPUT:      invert_in      = csr_wdata[0];
            CSR_DITHER_ENABLE:      dither_en_in   = csr_wdata[0];
            CSR_DITHER_WIDTH_LOG2:  width_log2_in  = csr_wdata;
            CSR_DITHER_HEIGHT_LOG2: height_log2_in = csr_wdata;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         invert_ff      <= 1'b0;
         dither_en_ff   <= 1'b0;
         width_log2_ff  <= 3'd2;
         height_log2_ff <= 3'd2;
      end else begin
         invert_ff      <= invert_in;
         dither_en_ff   <= dither_en_in;
         width_log2_ff  <= width_log2_in;
         height_log2_ff <= height_log2_in;
      end
   end

   // ---------------------------------------------------------- flow control
   logic s1_valid_ff, s1_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;   // result register can take a new item
   logic s1_load;    // stage 1 takes whatever the input presents
   logic req_accept;

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign s1_load    = !s1_valid_ff || out_free;
   assign req_stall  = !s1_load;
   assign req_accept = req_valid && s1_load;

   // ------------------------------------------------------ table addressing
   // Tile log2 is clamped to what the table side allows; x of pixel i is
   // column*8+i, so the low three bits of x are just i.
   logic [LOG2_W-1:0]                       lw, lh;
   logic [7:0]                              mask_x, mask_y, row_part;
   logic [PIXELS_PER_GROUP-1:0][TABLE_AW-1:0] idx;

   always_comb begin
      lw       = (width_log2_ff  > LOG2_W'(MAX_SIDE_LOG2)) ? LOG2_W'(MAX_SIDE_LOG2)
                                                           : width_log2_ff;
      lh       = (height_log2_ff > LOG2_W'(MAX_SIDE_LOG2)) ? LOG2_W'(MAX_SIDE_LOG2)
                                                           : height_log2_ff;
      mask_x   = 8'((16'd1 << lw) - 16'd1);
      mask_y   = 8'((16'd1 << lh) - 16'd1);
      row_part = 8'({8'h00, req_item.pixel_row & mask_y} << lw);
      for (int i = 0; i < PIXELS_PER_GROUP; i++) begin
         idx[i] = TABLE_AW'(row_part + ({req_item.byte_column[4:0], 3'(i)} & mask_x));
      end
   end

   // All eight entries of a group sit in one bank row, so pixel 0 gives the row.
   tbl_wr_type tbl_wr;
   tbl_rd_type tbl_rd;
   logic [NUM_BANKS-1:0][PIXEL_W-1:0] tbl_data;

   assign tbl_wr.en    = req_accept && (req_item.cmd == CMD_TABLE_WRITE);
   assign tbl_wr.slot  = req_item.table_slot;
   assign tbl_wr.level = req_item.table_level;
   assign tbl_rd.en    = s1_load;
   assign tbl_rd.addr  = idx[0][TABLE_AW-1:BANK_SEL_W];

   odp_table u_table (
      .clock   (clock),
      .wr      (tbl_wr),
      .rd      (tbl_rd),
      .rd_data (tbl_data)
   );

   // --------------------------------------------------------------- stage 1
   logic [PIXELS_PER_GROUP-1:0][PIXEL_W-1:0]    s1_pix_ff;
   logic [PIXELS_PER_GROUP-1:0][BANK_SEL_W-1:0] s1_sel_ff;
   logic [5:0]                                  s1_column_ff;
   logic [7:0]                                  s1_row_ff;

   assign s1_valid_in = s1_load ? (req_accept && (req_item.cmd == CMD_CONVERT))
                                : s1_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         // low byte of pixels_left is the leftmost pixel
         s1_pix_ff    <= {req_item.pixels_right, req_item.pixels_left};
         s1_column_ff <= req_item.byte_column;
         s1_row_ff    <= req_item.pixel_row;
         for (int i = 0; i < PIXELS_PER_GROUP; i++) begin
            s1_sel_ff[i] <= idx[i][BANK_SEL_W-1:0];
         end
      end
   end

   // ------------------------------------------------------- compare and pack
   odp_rsp_type rsp_item_ff, rsp_item_in;
   logic        bit_val;

   always_comb begin
      bit_val     = 1'b0;
      rsp_item_in = '0;
      for (int i = 0; i < PIXELS_PER_GROUP; i++) begin
         if (dither_en_ff) begin
            bit_val = s1_pix_ff[i] >= tbl_data[s1_sel_ff[i]];
         end else begin
            bit_val = s1_pix_ff[i] > FIXED_THRESHOLD;
         end
         rsp_item_in.packed_byte[PIXELS_PER_GROUP-1-i] = bit_val ^ invert_ff;
      end
      rsp_item_in.out_column = s1_column_ff;
      rsp_item_in.out_row    = s1_row_ff;
   end

   assign rsp_valid_in = out_free ? s1_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   // ------------------------------------------------------------ assertions
   `ODP_ASSERT_NOW(a_stall_only_when_full, req_stall, rsp_valid && rsp_stall,
                   "input stalled without a held result")
   `ODP_ASSERT_NEXT(a_s1_tracks_cmd, !reset && req_accept,
                    s1_valid_ff == $past(req_item.cmd == CMD_CONVERT),
                    "stage 1 valid does not follow accepted command")
   `ODP_ASSERT_NEXT(a_s1_moves_out, !reset && s1_valid_ff && out_free, rsp_valid,
                    "stage 1 item lost on the way to the result register")

endmodule

// File: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the ordered dither 1bpp packer
// Streams table-write and convert items through the block under random idling
// on both sides and compares every packed byte with a bit-exact predictor.
// ----------------------------------------------------------------------------
module tb_top
   import odp_pkg::*;
();

   // Overall guard on simulated time (2 time units per clock)
   localparam int RUN_LIMIT     = 2_000_000;
   // Idle this long once nothing is owed, before touching the CSRs
   localparam int SETTLE_CYCLES = 6;
   // Bound on the final wait for outstanding bytes
   localparam int DRAIN_LIMIT   = 5000;
   // Length of the receiver hold-off that backs the pipe up into req_stall
   localparam int HOLD_CYCLES   = 300;
   localparam int ITEMS_PER_RUN = 200;

   // -------------------------------------------------------------------------
   // Scoreboard: shadow copy of the CSRs and the dither table, the packed
   // bytes still owed by the block, and the mismatch count.
   // -------------------------------------------------------------------------
   class dither_scoreboard;
      logic        invert;
      logic        dither_on;
      logic [2:0]  width_log2;
      logic [2:0]  height_log2;
      logic [7:0]  level_table [TABLE_DEPTH];
      bit          slot_written [TABLE_DEPTH];
      odp_rsp_type owed_bytes [$];
      int          mismatches;

      function new();
         invert      = 1'b0;
         dither_on   = 1'b0;
         width_log2  = 3'd2;
         height_log2 = 3'd2;
         mismatches  = 0;
         foreach (level_table[s]) begin
            level_table[s]  = '0;
            slot_written[s] = 1'b0;
         end
      endfunction

      function void set_register(csr_index_type idx, logic [2:0] value);
         case (idx)
            CSR_INVERT_OUTPUT:      invert      = value[0];
            CSR_DITHER_ENABLE:      dither_on   = value[0];
            CSR_DITHER_WIDTH_LOG2:  width_log2  = value;
            CSR_DITHER_HEIGHT_LOG2: height_log2 = value;
            default: ;
         endcase
      endfunction

      // Table entry seen by pixel i of a group; oversized tiles clamp to the
      // largest side that fits, and the index wraps to the table depth.
      function int unsigned tile_slot(logic [5:0] col, logic [7:0] row, int unsigned i);
         int unsigned lw, lh, x, y;
         lw = (width_log2 > MAX_SIDE_LOG2) ? MAX_SIDE_LOG2 : width_log2;
         lh = (height_log2 > MAX_SIDE_LOG2) ? MAX_SIDE_LOG2 : height_log2;
         x  = (32'(col) << 3) + i;
         y  = 32'(row);
         return (((y & ((1 << lh) - 1)) << lw) + (x & ((1 << lw) - 1))) % TABLE_DEPTH;
      endfunction

      function logic [7:0] threshold_at(logic [5:0] col, logic [7:0] row, int unsigned i);
         return dither_on ? level_table[tile_slot(col, row, i)] : FIXED_THRESHOLD;
      endfunction

      function odp_rsp_type pack_group(odp_req_type r);
         odp_rsp_type res;
         logic [7:0]  p, thr;
         logic        lit;
         res.out_column = r.byte_column;
         res.out_row    = r.pixel_row;
         for (int i = 0; i < PIXELS_PER_GROUP; i++) begin
            p   = (i < 4) ? r.pixels_left[8*i +: 8] : r.pixels_right[8*(i-4) +: 8];
            thr = threshold_at(r.byte_column, r.pixel_row, i);
            lit = dither_on ? (p >= thr) : (p > thr);
            res.packed_byte[7-i] = lit ^ invert;
         end
         return res;
      endfunction

      function void note_request(odp_req_type r);
         if (r.cmd == CMD_TABLE_WRITE) begin
            level_table[r.table_slot]  = r.table_level;
            slot_written[r.table_slot] = 1'b1;
         end else begin
            owed_bytes.push_back(pack_group(r));
         end
      endfunction

      task report_mismatch(string msg);
         $display("mismatch @%0t: %s", $time, msg);
         mismatches++;
      endtask

      task check_response(odp_rsp_type got);
         odp_rsp_type want;
         if (owed_bytes.size() == 0) begin
            report_mismatch($sformatf("unexpected byte %0h col %0d row %0d",
                                      got.packed_byte, got.out_column, got.out_row));
            return;
         end
         want = owed_bytes.pop_front();
         if (got.packed_byte !== want.packed_byte)
            report_mismatch($sformatf("packed_byte %0h, want %0h (col %0d row %0d)",
                                      got.packed_byte, want.packed_byte,
                                      want.out_column, want.out_row));
         if (got.out_column !== want.out_column)
            report_mismatch($sformatf("out_column %0d, want %0d",
                                      got.out_column, want.out_column));
         if (got.out_row !== want.out_row)
            report_mismatch($sformatf("out_row %0d, want %0d", got.out_row, want.out_row));
      endtask

      function int pending();
         return owed_bytes.size();
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Signals
   // -------------------------------------------------------------------------
   logic          clock;
   logic          reset;
   logic          req_valid;
   logic          req_stall;
   odp_req_type   req_item;
   logic          rsp_valid;
   logic          rsp_stall;
   odp_rsp_type   rsp_item;
   logic          csr_valid;
   logic          csr_ready;
   csr_index_type csr_index;
   logic [2:0]    csr_wdata;

   dither_scoreboard sb;
   logic hold_off;       // forces rsp_stall for the long back-pressure window
   int   items_taken;    // input items accepted so far
   int   tx_quiet;       // remaining no-gap stretch on the sender side

   ordered_dither_1bpp_packer_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Hard stop if the handshakes ever lock up
   initial begin
      #RUN_LIMIT;
      $display("RESULT: ERROR");
      $finish;
   end

   // -------------------------------------------------------------------------
   // Idle pattern shared by both sides: mostly no gap or a short one, a few
   // long ones, and now and then a quiet stretch with no gaps at all.
   // -------------------------------------------------------------------------
   function automatic int pick_gap(ref int quiet);
      int roll;
      if (quiet > 0) begin
         quiet--;
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
         quiet = $urandom_range(20, 100);
         return 0;
      end
      if (roll < 55) return 0;
      if (roll < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 24);
   endfunction

   function automatic odp_req_type make_req(input cmd_type     cmd,
                                            input logic [31:0] left,
                                            input logic [31:0] right,
                                            input logic [5:0]  col,
                                            input logic [7:0]  row,
                                            input logic [7:0]  slot,
                                            input logic [7:0]  level);
      odp_req_type r;
      r.cmd          = cmd;
      r.pixels_left  = left;
      r.pixels_right = right;
      r.byte_column  = col;
      r.pixel_row    = row;
      r.table_slot   = slot;
      r.table_level  = level;
      return r;
   endfunction

   // -------------------------------------------------------------------------
   // Sender. Entered just after an accepting edge (or before the first item);
   // drives at the falling edge, holds the item until an edge with no stall.
   // -------------------------------------------------------------------------
   task automatic send_item(input odp_req_type r);
      int gap;
      gap = pick_gap(tx_quiet);
      @(negedge clock);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_item  = r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_request(r);
      items_taken++;
   endtask

   task automatic send_table_write(input logic [7:0] slot, input logic [7:0] level);
      send_item(make_req(CMD_TABLE_WRITE, $urandom, $urandom, 6'($urandom),
                         8'($urandom), slot, level));
   endtask

   // A convert at a mostly on-screen position. In dither mode any entry the
   // group will read is loaded first, so no unwritten entry ever decides a bit.
   // Pixels are biased toward their own threshold to hit the compare edge.
   task automatic send_convert();
      odp_req_type r;
      logic [5:0]  col;
      logic [7:0]  row, thr, p;
      int          roll;
      col = ($urandom_range(0, 4) == 0) ? 6'($urandom_range(50, 63))
                                        : 6'($urandom_range(0, 49));
      row = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(240, 255))
                                        : 8'($urandom_range(0, 239));
      if (sb.dither_on) begin
         for (int i = 0; i < PIXELS_PER_GROUP; i++)
            if (!sb.slot_written[sb.tile_slot(col, row, i)])
               send_table_write(8'(sb.tile_slot(col, row, i)), 8'($urandom));
      end
      r = make_req(CMD_CONVERT, '0, '0, col, row, 8'($urandom), 8'($urandom));
      for (int i = 0; i < PIXELS_PER_GROUP; i++) begin
         thr  = sb.threshold_at(col, row, i);
         roll = $urandom_range(0, 9);
         if (roll < 5)      p = 8'($urandom);
         else if (roll < 9) p = thr + 8'($urandom_range(0, 2)) - 8'd1;
         else               p = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
         if (i < 4) r.pixels_left[8*i +: 8]       = p;
         else       r.pixels_right[8*(i-4) +: 8]  = p;
      end
      send_item(r);
   endtask

   // Drop valid, wait until every owed byte is back, then let the pipe settle.
   task automatic wait_idle();
      @(negedge clock);
      req_valid = 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input csr_index_type idx, input logic [2:0] value);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.set_register(idx, value);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // One setting of the CSRs followed by a random mix of converts and table
   // writes. The single-bit registers also get random upper data bits.
   task automatic run_setting(input logic inv, input logic dith,
                              input logic [2:0] wl2, input logic [2:0] hl2,
                              input int count);
      logic [2:0] v;
      wait_idle();
      v = 3'($urandom);
      v[0] = inv;
      write_register(CSR_INVERT_OUTPUT, v);
      v = 3'($urandom);
      v[0] = dith;
      write_register(CSR_DITHER_ENABLE, v);
      write_register(CSR_DITHER_WIDTH_LOG2, wl2);
      write_register(CSR_DITHER_HEIGHT_LOG2, hl2);
      repeat (count) begin
         if ($urandom_range(0, 5) == 0)
            send_table_write(8'($urandom), 8'($urandom));
         else
            send_convert();
      end
   endtask

   // -------------------------------------------------------------------------
   // Receiver: random stalls, overridden by the hold-off window.
   // -------------------------------------------------------------------------
   initial begin
      int stall_left, run_left, rx_quiet;
      stall_left = 0;
      run_left   = 0;
      rx_quiet   = 0;
      rsp_stall  = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left == 0 && run_left == 0) begin
            stall_left = pick_gap(rx_quiet);
            run_left   = $urandom_range(1, 12);
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall = 1'b1;
         end else begin
            run_left--;
            rsp_stall = hold_off;
         end
      end
   end

   // Long hold-off once traffic is flowing: the sender keeps offering items,
   // so the result register fills and req_stall has to rise.
   initial begin
      hold_off = 1'b0;
      wait (items_taken >= 300);
      @(posedge clock);
      hold_off = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_off = 1'b0;
   end

   // Every result accepted at an edge is checked against the oldest owed byte
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_response(rsp_item);
   end

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      int waited;
      sb          = new();
      items_taken = 0;
      tx_quiet    = 0;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_item    = '0;
      csr_valid   = 1'b0;
      csr_index   = CSR_INVERT_OUTPUT;
      csr_wdata   = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed items at the reset setting (fixed threshold, no invert):
      // all-dark and all-bright groups, pixels right around 128, screen
      // corners and positions past the screen edge, and table writes at the
      // extreme slots and levels.
      send_item(make_req(CMD_CONVERT, 32'h0, 32'h0, 6'd0, 8'd0, 8'd0, 8'd0));
      send_item(make_req(CMD_CONVERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd49, 8'd239,
                         8'hFF, 8'hFF));
      send_item(make_req(CMD_CONVERT, 32'h8081_7F80, 32'h7F81_8081, 6'd63, 8'd255,
                         8'h00, 8'hFF));
      send_item(make_req(CMD_CONVERT, 32'hFF00_FF00, 32'h00FF_00FF, 6'd50, 8'd240,
                         8'hAA, 8'h55));
      send_table_write(8'd0, 8'd0);
      send_table_write(8'd255, 8'd255);
      send_item(make_req(CMD_TABLE_WRITE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd63,
                         8'd255, 8'h55, 8'hAA));
      send_item(make_req(CMD_CONVERT, 32'h8080_8080, 32'h8181_8181, 6'd1, 8'd1,
                         8'hFF, 8'hFF));
      repeat (6) send_convert();

      // CSR settings: extremes, single-axis tiles, oversized tiles that must
      // clamp, invert with both compare modes, then a couple of random ones.
      run_setting(1'b1, 1'b0, 3'd0, 3'd0, ITEMS_PER_RUN);
      run_setting(1'b0, 1'b1, 3'd2, 3'd2, ITEMS_PER_RUN);
      run_setting(1'b1, 1'b1, 3'd0, 3'd0, ITEMS_PER_RUN);
      run_setting(1'b0, 1'b1, 3'd4, 3'd4, ITEMS_PER_RUN);
      run_setting(1'b1, 1'b1, 3'd7, 3'd7, ITEMS_PER_RUN);
      run_setting(1'b0, 1'b1, 3'd0, 3'd4, ITEMS_PER_RUN);
      run_setting(1'b0, 1'b1, 3'd5, 3'd1, ITEMS_PER_RUN);
      run_setting(1'b1, 1'b1, 3'd3, 3'd6, ITEMS_PER_RUN);
      run_setting(1'($urandom), 1'($urandom), 3'($urandom), 3'($urandom), ITEMS_PER_RUN);
      run_setting(1'($urandom), 1'b1, 3'($urandom), 3'($urandom), ITEMS_PER_RUN);

      // Drain with a bound, then let any stray result show up
      @(negedge clock);
      req_valid = 1'b0;
      waited = 0;
      while (sb.pending() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.pending() != 0)
         sb.report_mismatch($sformatf("%0d bytes never came out", sb.pending()));

      if (sb.mismatches == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
